/* hw/rtl/smf_pkg.sv */
// Shared types and constants of the sliding median filter.
package smf_pkg;

    // Largest window the filter supports
    localparam int MaxWidth = 15;
    // Range sample width in bits
    localparam int SampleW  = 16;
    // Width register and sample-count width
    localparam int WidthW   = $clog2(MaxWidth + 1);
    // Lag ("after") fits in one bit less than the width
    localparam int AfterW   = WidthW - 1;
    // Rank of an entry inside the window
    localparam int RankW    = WidthW;

    // Width register value after reset
    localparam logic [WidthW-1:0] WidthReset = WidthW'(3);

    typedef logic [SampleW-1:0] sample_t;
    typedef logic [WidthW-1:0]  width_t;
    typedef logic [AfterW-1:0]  after_t;

    // Window of newest samples, entry 0 is the newest
    typedef logic [MaxWidth-1:0][SampleW-1:0] win_t;

    // Results caused by one accepted item
    typedef struct packed {
        logic   main;   // centered result (median or raw) pending
        logic   med;    // centered result is a median
        logic   last;   // item ended the scan
        after_t tail;   // raw tail results still to flush
    } job_t;

endpackage

/* hw/rtl/smf_window.sv */
// Sample window shift register, scan sample count and per-item job decode.
module smf_window (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  smf_pkg::sample_t sample,
    input  logic             last,
    input  smf_pkg::width_t  width,
    input  logic             cfg_clear,
    output smf_pkg::win_t    window,
    output smf_pkg::job_t    job
);

    smf_pkg::win_t   window_reg;
    smf_pkg::win_t   window_next;
    smf_pkg::width_t seen_reg;
    smf_pkg::width_t seen_next;
    smf_pkg::width_t seen_inc;
    smf_pkg::after_t after;
    logic            pass;

    // Saturating count including the item being accepted
    assign seen_inc = (seen_reg < smf_pkg::WidthW'(smf_pkg::MaxWidth)) ?
                      seen_reg + 1'b1 : smf_pkg::WidthW'(smf_pkg::MaxWidth);

    assign pass  = (width <= smf_pkg::WidthW'(1));
    assign after = smf_pkg::AfterW'(width >> 1);

    // Job decode for the accepted item
    always_comb
    begin
        job.main = pass || (seen_inc > {1'b0, after});
        job.med  = !pass && (seen_inc >= width);
        job.last = last;
        if (!last || pass)
        begin
            job.tail = '0;
        end
        else if (seen_inc > {1'b0, after})
        begin
            job.tail = after;
        end
        else
        begin
            job.tail = seen_inc[smf_pkg::AfterW-1:0];
        end
    end

    // Shift in the new sample, newest at entry 0
    always_comb
    begin
        window_next = window_reg;
        if (accept)
        begin
            window_next = {window_reg[smf_pkg::MaxWidth-2:0], sample};
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    // Sample count of the current scan
    always_comb
    begin
        seen_next = seen_reg;
        if (cfg_clear)
        begin
            seen_next = '0;
        end
        else if (accept)
        begin
            seen_next = last ? '0 : seen_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    assign window = window_reg;

`ifndef NO_ASSERTIONS
    // The end of a scan restarts the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (seen_reg == '0))
        else $error("sample count not cleared after scan end");

    // A median is only requested once the window is full of this scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && job.med) |-> (seen_inc >= width && job.main))
        else $error("median requested on partial window");
`endif

endmodule

/* hw/rtl/smf_median.sv */
// Median of the newest window entries by stable ranking and selection.
module smf_median (
    input  smf_pkg::win_t    window,
    input  smf_pkg::width_t  width,
    output smf_pkg::sample_t median
);

    logic [smf_pkg::MaxWidth-1:0] below [smf_pkg::MaxWidth];
    logic [smf_pkg::RankW-1:0]    rank  [smf_pkg::MaxWidth];
    logic [smf_pkg::RankW-1:0]    hi_idx;
    logic [smf_pkg::RankW-1:0]    lo_idx;
    smf_pkg::sample_t             hi_val;
    smf_pkg::sample_t             lo_val;
    logic [smf_pkg::SampleW:0]    pair_sum;

    assign hi_idx = smf_pkg::RankW'(width >> 1);
    assign lo_idx = hi_idx - 1'b1;

    // Rank of each entry: smaller entries, ties broken by position
    always_comb
    begin
        for (int i = 0; i < smf_pkg::MaxWidth; i++)
        begin
            for (int j = 0; j < smf_pkg::MaxWidth; j++)
            begin
                below[i][j] = (j != i) && (smf_pkg::WidthW'(j) < width) &&
                              ((window[j] < window[i]) ||
                               ((window[j] == window[i]) && (j < i)));
            end
            rank[i] = smf_pkg::RankW'($countones(below[i]));
        end
    end

    // Pick the two middle entries
    always_comb
    begin
        hi_val = '0;
        lo_val = '0;
        for (int i = 0; i < smf_pkg::MaxWidth; i++)
        begin
            if (smf_pkg::WidthW'(i) < width)
            begin
                if (rank[i] == hi_idx)
                begin
                    hi_val = hi_val | window[i];
                end
                if (rank[i] == lo_idx)
                begin
                    lo_val = lo_val | window[i];
                end
            end
        end
    end

    // Odd width: middle entry; even width: floor of the mean
    assign pair_sum = {1'b0, hi_val} + {1'b0, lo_val};
    assign median   = width[0] ? hi_val : pair_sum[smf_pkg::SampleW:1];

endmodule

/* hw/rtl/smf_seq.sv */
// Result sequencer: pending job, tail flush and output register.
module smf_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  smf_pkg::job_t    job_in,
    input  smf_pkg::win_t    window,
    input  smf_pkg::sample_t median,
    input  smf_pkg::width_t  width,
    output logic             in_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output smf_pkg::sample_t m_tdata,
    output logic             m_tlast
);

    smf_pkg::job_t    job_reg;
    smf_pkg::job_t    job_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    smf_pkg::sample_t out_data_reg;
    smf_pkg::sample_t out_data_next;
    logic             out_last_reg;
    logic             out_last_next;
    logic             load_ok;
    logic             busy;
    logic             emit;
    logic             final_emit;
    logic [smf_pkg::WidthW-1:0] idx;
    smf_pkg::sample_t pick;
    logic             pick_last;

    assign load_ok    = !out_valid_reg || m_tready;
    assign busy       = job_reg.main || (job_reg.tail != '0);
    assign emit       = busy && load_ok;
    assign final_emit = emit && (job_reg.main ? (job_reg.tail == '0)
                                              : (job_reg.tail == smf_pkg::AfterW'(1)));
    assign in_ready   = !busy || final_emit;

    // Select the next result: centered one first, then tail oldest first
    always_comb
    begin
        if (job_reg.main)
        begin
            idx       = {1'b0, smf_pkg::AfterW'(width >> 1)};
            pick_last = job_reg.last && (job_reg.tail == '0);
        end
        else
        begin
            idx       = {1'b0, job_reg.tail - 1'b1};
            pick_last = job_reg.last && (job_reg.tail == smf_pkg::AfterW'(1));
        end
        pick = (job_reg.main && job_reg.med) ? median : window[idx];
    end

    // Job bookkeeping
    always_comb
    begin
        job_next = job_reg;
        if (emit)
        begin
            if (job_reg.main)
            begin
                job_next.main = 1'b0;
            end
            else
            begin
                job_next.tail = job_reg.tail - 1'b1;
            end
        end
        if (accept)
        begin
            job_next = job_in;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load_ok)
        begin
            out_valid_next = emit;
            out_data_next  = pick;
            out_last_next  = pick_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // Every scan end produces at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && job_in.last) |=> busy)
        else $error("scan end left no result pending");

    // Tail flush counts down one per delivered slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !job_reg.main && !accept) |=> (job_reg.tail == $past(job_reg.tail) - 1'b1))
        else $error("tail count skipped");

    // New item only taken when the pending job finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && busy) |-> final_emit)
        else $error("item taken over a pending job");
`endif

endmodule

/* hw/rtl/sliding_median_filter.sv */
// Top level of the sliding window median filter for range scans.
//
//  channel   direction  tdata               tlast
//  s_*       in         range_sample[15:0]  scan_end
//  m_*       out        filtered_sample     scan_last
//  cfg_wr_*  in         window_width[3:0]   -
//
// One item accepted per cycle while the output is not stalled and no tail is flushing; its results
// pass through the pending job register and the output register to m_*. An item ending a scan holds
// s_tready low while its tail flushes, one result per cycle unless m_tready stalls the output register:
// up to width/2 + 1 results, 8 at width 15. m_tready low stalls the output register and, once the job is
// pending, the input. Reset clears the width to 3, the scan count and all pending results.
module sliding_median_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [smf_pkg::SampleW-1:0]  s_tdata,    // [15:0] range_sample
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [smf_pkg::SampleW-1:0]  m_tdata,    // [15:0] filtered_sample
    output logic                         m_tlast,
    input  logic                         cfg_wr_en,
    input  logic [smf_pkg::WidthW-1:0]   cfg_wr_data // [3:0] window_width
);

    smf_pkg::width_t  width_reg;
    smf_pkg::width_t  width_next;
    smf_pkg::win_t    window;
    smf_pkg::job_t    job;
    smf_pkg::sample_t median;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    // Window width register
    assign width_next = cfg_wr_en ? cfg_wr_data : width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= smf_pkg::WidthReset;
        end
        else
        begin
            width_reg <= width_next;
        end
    end

    smf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (s_tdata),
        .last      (s_tlast),
        .width     (width_reg),
        .cfg_clear (cfg_wr_en),
        .window    (window),
        .job       (job)
    );

    smf_median u_median (
        .window (window),
        .width  (width_reg),
        .median (median)
    );

    smf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .job_in   (job),
        .window   (window),
        .median   (median),
        .width    (width_reg),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/tb_sliding_median_filter.sv */
// Self-checking testbench for the sliding median filter: streamed range scans against a predictor.
module tb_sliding_median_filter;

    localparam int TargetItems   = 430;
    localparam int FlushCycles   = 16;     // output lag plus the longest tail flush, with margin
    localparam int HoldOffCycles = 150;
    localparam int CycleLimit    = 400000;

    typedef struct {
        smf_pkg::sample_t range_mm;
        logic             scan_end;
        int               gap;             // idle cycles before the item is offered
    } range_item_t;

    typedef struct {
        smf_pkg::sample_t value;
        logic             last;
    } filtered_t;

    // DUT connections, all inputs known from time zero
    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    smf_pkg::sample_t s_tdata     = '0;    // [15:0] range_sample
    logic             s_tlast     = 1'b0;  // scan_end
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    smf_pkg::sample_t m_tdata;             // [15:0] filtered_sample
    logic             m_tlast;             // scan_last
    logic             cfg_wr_en   = 1'b0;
    smf_pkg::width_t  cfg_wr_data = '0;    // [3:0] window_width

    // Predictor state
    smf_pkg::sample_t window_hist [smf_pkg::MaxWidth];   // newest first
    int               seen_cnt = 0;
    smf_pkg::width_t  width_q  = smf_pkg::WidthReset;

    range_item_t range_queue  [$];
    filtered_t   filtered_due [$];

    int tx_max = 0;
    int rx_max = 0;
    int hold_req = 0;
    int samples_sent = 0;
    int scans_sent = 0;
    int widths_used = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int width_plan [8] = '{0, 1, 2, 15, 14, 4, 7, 8};

    sliding_median_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Expected results caused by one accepted sample
    function automatic void predict_filtered(smf_pkg::sample_t range_mm, logic scan_end);
        int                        w;
        int                        after_n;
        int                        queued;
        int                        k;
        smf_pkg::sample_t          sorted [smf_pkg::MaxWidth];
        smf_pkg::sample_t          key;
        logic [smf_pkg::SampleW:0] pair_sum;
        w      = int'(width_q);
        queued = filtered_due.size();
        for (int i = smf_pkg::MaxWidth - 1; i > 0; i--)
        begin
            window_hist[i] = window_hist[i - 1];
        end
        window_hist[0] = range_mm;
        if (seen_cnt < smf_pkg::MaxWidth)
        begin
            seen_cnt++;
        end
        if (w <= 1)
        begin
            // pass-through, scan_last follows scan_end
            filtered_due.push_back('{value: range_mm, last: scan_end});
        end
        else
        begin
            after_n = w - 1 - (w - 1) / 2;
            if (seen_cnt >= w)
            begin
                // full window: sort and take the middle
                for (int i = 0; i < w; i++)
                begin
                    key = window_hist[i];
                    k   = i;
                    while (k > 0 && sorted[k - 1] > key)
                    begin
                        sorted[k] = sorted[k - 1];
                        k--;
                    end
                    sorted[k] = key;
                end
                if (w % 2 == 1)
                begin
                    filtered_due.push_back('{value: sorted[w / 2], last: 1'b0});
                end
                else
                begin
                    pair_sum = {1'b0, sorted[w / 2 - 1]} + {1'b0, sorted[w / 2]};
                    filtered_due.push_back('{value: pair_sum[smf_pkg::SampleW:1], last: 1'b0});
                end
            end
            else if (seen_cnt > after_n)
            begin
                // window runs past the scan start: raw sample
                filtered_due.push_back('{value: window_hist[after_n], last: 1'b0});
            end
            if (scan_end)
            begin
                // flush the tail raw, oldest first
                for (int i = after_n - 1; i >= 0; i--)
                begin
                    if (i < seen_cnt)
                    begin
                        filtered_due.push_back('{value: window_hist[i], last: 1'b0});
                    end
                end
                if (filtered_due.size() > queued)
                begin
                    filtered_due[filtered_due.size() - 1].last = 1'b1;
                end
            end
        end
        if (scan_end)
        begin
            seen_cnt = 0;
        end
    endfunction

    // Sender: offers queued samples, predicts on acceptance
    always @(posedge clk)
    begin : driver
        range_item_t next_item;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_filtered(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready)
            begin
                if (range_queue.size() != 0 && range_queue[0].gap == 0)
                begin
                    next_item = range_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.range_mm;
                    s_tlast  <= next_item.scan_end;
                end
                else
                begin
                    if (range_queue.size() != 0)
                    begin
                        range_queue[0].gap = range_queue[0].gap - 1;
                    end
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks results in order, random stalls and one long hold-off
    int rx_wait   = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge clk)
    begin : monitor
        filtered_t due;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (filtered_due.size() == 0)
                begin
                    mismatch_count++;
                    $error("filtered_sample: expected no result, got %0d (scan_last %0b)",
                           m_tdata, m_tlast);
                end
                else
                begin
                    due = filtered_due.pop_front();
                    if (m_tdata !== due.value)
                    begin
                        mismatch_count++;
                        $error("filtered_sample: expected %0d, got %0d", due.value, m_tdata);
                    end
                    if (m_tlast !== due.last)
                    begin
                        mismatch_count++;
                        $error("scan_last: expected %0b, got %0b", due.last, m_tlast);
                    end
                end
                rx_wait = $urandom_range(0, rx_max);
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HoldOffCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_sample(smf_pkg::sample_t range_mm, logic scan_end);
        range_queue.push_back('{range_mm: range_mm, scan_end: scan_end,
                                gap: $urandom_range(0, tx_max)});
        samples_sent++;
    endtask

    task automatic queue_values(input smf_pkg::sample_t vals [$], input logic close);
        foreach (vals[i])
        begin
            queue_sample(vals[i], close && i == vals.size() - 1);
        end
        if (close)
        begin
            scans_sent++;
        end
    endtask

    // One scan with random content; close = 0 leaves it open
    task automatic queue_scan(int len, logic close);
        int               mode;
        smf_pkg::sample_t v;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0:       v = smf_pkg::sample_t'($urandom_range(1200, 1215));  // many ties
                1:       v = $urandom_range(0, 1) ? '1 : '0;
                default: v = smf_pkg::sample_t'($urandom);
            endcase
            queue_sample(v, close && i == len - 1);
        end
        if (close)
        begin
            scans_sent++;
        end
    endtask

    // Wait until every sample is taken and every result has come back
    task automatic drain_filter();
        do
            @(negedge clk);
        while (range_queue.size() != 0 || s_tvalid || filtered_due.size() != 0);
        repeat (FlushCycles) @(negedge clk);
    endtask

    task automatic set_width(smf_pkg::width_t w);
        drain_filter();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        width_q  = w;
        seen_cnt = 0;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        widths_used++;
    endtask

    initial
    begin : stimulus
        int len;
        int n_scans;
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes at the reset width, even width, pass-through, short scans
        tx_max = 3;
        rx_max = 3;
        queue_values('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF}, 1'b1);
        queue_values('{16'hFFFF}, 1'b1);
        set_width(smf_pkg::width_t'(4));
        queue_values('{16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF}, 1'b1);
        set_width(smf_pkg::width_t'(0));
        queue_values('{16'h0000, 16'hFFFF}, 1'b1);
        set_width(smf_pkg::width_t'(1));
        queue_values('{16'h5555, 16'hAAAA}, 1'b1);
        set_width(smf_pkg::width_t'(smf_pkg::MaxWidth));
        queue_values('{16'h0003, 16'h0002, 16'h0001}, 1'b1);   // shorter than the lag
        set_width(smf_pkg::width_t'(5));
        queue_values('{16'h0010, 16'h0020, 16'h0030, 16'h0040}, 1'b0);  // width rewritten mid-scan

        // Back-to-back input against a long output hold-off
        set_width(smf_pkg::width_t'(smf_pkg::MaxWidth));
        tx_max = 0;
        rx_max = 0;
        hold_req++;
        queue_scan(40, 1'b1);
        queue_scan(40, 1'b1);

        // Random phases, each with its own width and idling mix
        phase = 0;
        while (samples_sent < TargetItems)
        begin
            set_width(phase < 8 ? smf_pkg::width_t'(width_plan[phase])
                                : smf_pkg::width_t'($urandom_range(0, 15)));
            case ($urandom_range(0, 2))
                0:       tx_max = 0;
                1:       tx_max = $urandom_range(1, 14);
                default: tx_max = 14;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_max = 0;
                1:       rx_max = $urandom_range(1, 14);
                default: rx_max = 14;
            endcase
            n_scans = $urandom_range(1, 4);
            for (int s = 0; s < n_scans; s++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    len = $urandom_range(1, 3);
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    len = $urandom_range(20, 40);
                end
                else
                begin
                    len = $urandom_range(4, 20);
                end
                queue_scan(len, !(s == n_scans - 1 && $urandom_range(0, 5) == 0));
            end
            phase++;
        end
        drain_filter();

        $display("Run covered %0d samples in %0d closed scans over %0d width settings,",
                 samples_sent, scans_sent, widths_used);
        $display("%0d results checked, with a long output hold-off and open scans cut by rewrites.",
                 results_checked);
        if (mismatch_count == 0)
        begin
            $display("** sliding_median_filter: PASSED **");
        end
        else
        begin
            $display("** sliding_median_filter: FAILED **");
        end
        $finish;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CycleLimit);
        $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                 filtered_due.size());
        $display("** sliding_median_filter: FAILED **");
        $finish;
    end

endmodule
